### src/dpbd_pkg.sv
// Shared types, codes and constants of the delta-palette bitstream decoder.
// Used by the front queue, the back decoder, the top level and the checker.
// Depends on nothing.
`timescale 1ns / 1ps

package dpbd_pkg;

	// Field widths fixed by the item formats.
	localparam int unsigned IDX_W    = 8;
	localparam int unsigned RGB_W    = 24;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned PBITS_W  = 4;
	localparam int unsigned PCOUNT_W = 21;
	localparam int unsigned TAKEN_W  = 4;
	localparam int unsigned BITCNT_W = 3;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_INDEX   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT  = 2'd2;
	localparam int unsigned CFG_DATA_W = PCOUNT_W;

	// Request opcodes.
	localparam logic OP_PALETTE = 1'b0;
	localparam logic OP_DATA    = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [PBITS_W-1:0]  PBITS_RESET  = 4'd8;
	localparam logic [IDX_W-1:0]    FILL_RESET   = 8'd0;
	localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 21'd1;

	// Widest explicit color code and length of a delta field.
	localparam logic [PBITS_W-1:0] PBITS_MAX = 4'd8;
	localparam logic [TAKEN_W-1:0] DELTA_LEN = 4'd3;
	localparam logic [TAKEN_W-1:0] LOAD_MAX  = 4'd8;
	localparam logic [BITCNT_W-1:0] LAST_BIT = 3'd7;

	// Request queue between front and back.
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = 1;
	localparam int unsigned QCNT_W      = 2;
	localparam logic [QCNT_W-1:0] QUEUE_FULL = 2'd2;

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_SECOND,
		PH_DELTA,
		PH_LOAD
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_FILL,
		BK_BITS,
		BK_END
	} back_state_t;

	typedef struct packed {
		logic              opcode;
		logic [IDX_W-1:0]  palette_index;
		logic [RGB_W-1:0]  palette_rgb;
		logic [BYTE_W-1:0] data_byte;
	} item_t;

	// Head of the request queue as seen by the back part.
	typedef struct packed {
		logic  valid;
		logic  is_data;
		item_t item;
	} head_t;

	typedef struct packed {
		logic [PBITS_W-1:0]  palette_bits;
		logic [IDX_W-1:0]    fill_index;
		logic [PCOUNT_W-1:0] pixel_count;
	} cfg_t;

	// Delta applied by a delta code: -4..-1 for codes 0..3, +1..+4 for codes 4..7.
	function automatic logic [IDX_W-1:0] delta_step(input logic [2:0] sel);
		logic [IDX_W-1:0] step;
		if (sel[2]) begin
			step = {6'd0, sel[1:0]} + 8'd1;
		end else begin
			step = {6'b111111, sel[1:0]};
		end
		return step;
	endfunction

endpackage

### src/dpbd_in_if.sv
// Request channel of the decoder: palette writes and compressed bytes.
// Uses the field widths of dpbd_pkg.
`timescale 1ns / 1ps

interface dpbd_in_if;
	logic                         valid;
	logic                         ready;
	logic                         opcode;
	logic [dpbd_pkg::IDX_W-1:0]   palette_index;
	logic [dpbd_pkg::RGB_W-1:0]   palette_rgb;
	logic [dpbd_pkg::BYTE_W-1:0]  data_byte;

	modport source (output valid, opcode, palette_index, palette_rgb, data_byte, input ready);
	modport sink   (input valid, opcode, palette_index, palette_rgb, data_byte, output ready);
endinterface

### src/dpbd_out_if.sv
// Pixel channel of the decoder: one decoded pixel per transfer.
// Uses the field widths of dpbd_pkg.
`timescale 1ns / 1ps

interface dpbd_out_if;
	logic                       valid;
	logic                       ready;
	logic [dpbd_pkg::RGB_W-1:0] pixel_rgb;
	logic [dpbd_pkg::IDX_W-1:0] pixel_index;
	logic                       last_of_run;
	logic                       image_done;

	modport source (output valid, pixel_rgb, pixel_index, last_of_run, image_done, input ready);
	modport sink   (input valid, pixel_rgb, pixel_index, last_of_run, image_done, output ready);
endinterface

### src/dpbd_front.sv
// Front part: accepts requests into a two-entry queue and classifies them.
// Depends on dpbd_pkg and dpbd_in_if.
`timescale 1ns / 1ps

module dpbd_front (
	input  logic            clk,
	input  logic            arst_n,
	dpbd_in_if.sink         cmd,
	input  logic            pop,
	output dpbd_pkg::head_t head
);

	dpbd_pkg::item_t                slot_q [dpbd_pkg::QUEUE_DEPTH];
	logic [dpbd_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [dpbd_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [dpbd_pkg::QCNT_W-1:0]    count_q;
	logic                           push;
	dpbd_pkg::item_t                in_item;

	// Accept while the queue has room.
	assign cmd.ready = (count_q != dpbd_pkg::QUEUE_FULL);
	assign push      = cmd.valid && cmd.ready;

	assign in_item.opcode        = cmd.opcode;
	assign in_item.palette_index = cmd.palette_index;
	assign in_item.palette_rgb   = cmd.palette_rgb;
	assign in_item.data_byte     = cmd.data_byte;

	// Queue storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Present the oldest request and tell data bytes from palette writes.
	always_comb begin
		head.valid   = (count_q != '0);
		head.item    = slot_q[rd_ptr_q];
		head.is_data = (slot_q[rd_ptr_q].opcode == dpbd_pkg::OP_DATA);
	end

endmodule

### src/dpbd_back.sv
// Back part: palette memory, bit-serial code decoder and the pixel output register.
// Depends on dpbd_pkg and dpbd_out_if; takes requests from dpbd_front.
`timescale 1ns / 1ps

module dpbd_back #(
	parameter int unsigned PALETTE_DEPTH = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dpbd_pkg::head_t head,
	input  dpbd_pkg::cfg_t  cfg,
	output logic            pop,
	dpbd_out_if.source      pixels
);

	localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam logic [dpbd_pkg::IDX_W:0] IDX_LIMIT = (dpbd_pkg::IDX_W + 1)'(PALETTE_DEPTH);

	// Decoder state.
	dpbd_pkg::back_state_t              state_q, state_d;
	dpbd_pkg::phase_t                   phase_q, phase_d;
	logic [dpbd_pkg::IDX_W-1:0]         acc_q, acc_d;
	logic [dpbd_pkg::TAKEN_W-1:0]       taken_q, taken_d;
	logic [dpbd_pkg::IDX_W-1:0]         cur_q, cur_d;
	logic [dpbd_pkg::PCOUNT_W-1:0]      emitted_q, emitted_d;
	logic                               fill_done_q, fill_done_d;
	logic [dpbd_pkg::BYTE_W-1:0]        byte_q, byte_d;
	logic [dpbd_pkg::BITCNT_W-1:0]      bitcnt_q, bitcnt_d;

	// Pixel waiting to learn whether it ends its byte.
	logic                               pend_valid_q, pend_valid_d;
	logic [dpbd_pkg::IDX_W-1:0]         pend_idx_q, pend_idx_d;
	logic                               pend_done_q, pend_done_d;

	// Output register; the color comes straight from the memory read register.
	logic                               out_valid_q;
	logic [dpbd_pkg::IDX_W-1:0]         out_idx_q;
	logic                               out_last_q;
	logic                               out_done_q;
	logic                               out_oor_q;
	logic [dpbd_pkg::RGB_W-1:0]         rgb_q;

	logic [dpbd_pkg::RGB_W-1:0]         pal_mem [PALETTE_DEPTH];

	// Combinational helpers.
	logic                               out_free;
	logic                               step_ok;
	logic                               cur_bit;
	logic [dpbd_pkg::PBITS_W-1:0]       width;
	logic [dpbd_pkg::IDX_W-1:0]         acc_n;
	logic [dpbd_pkg::TAKEN_W-1:0]       taken_n;
	logic                               pix;
	logic [dpbd_pkg::IDX_W-1:0]         pix_color;
	logic [dpbd_pkg::PCOUNT_W-1:0]      limit;
	logic [dpbd_pkg::PCOUNT_W-1:0]      emitted_n;
	logic                               img_done;
	logic                               rel;
	logic [dpbd_pkg::IDX_W-1:0]         rel_idx;
	logic                               rel_last;
	logic                               rel_done;
	logic                               mem_we;

	assign out_free = !out_valid_q || pixels.ready;
	assign step_ok  = !pend_valid_q || out_free;
	assign cur_bit  = byte_q[bitcnt_q];
	assign width    = (cfg.palette_bits > dpbd_pkg::PBITS_MAX) ? dpbd_pkg::PBITS_MAX
	                                                          : cfg.palette_bits;
	assign limit    = (cfg.pixel_count == '0) ? dpbd_pkg::PCOUNT_W'(1) : cfg.pixel_count;
	assign emitted_n = emitted_q + 1'b1;
	assign img_done  = (emitted_n >= limit);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= dpbd_pkg::BK_IDLE;
			phase_q      <= dpbd_pkg::PH_FIRST;
			acc_q        <= '0;
			taken_q      <= '0;
			cur_q        <= '0;
			emitted_q    <= '0;
			fill_done_q  <= 1'b0;
			bitcnt_q     <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			phase_q      <= phase_d;
			acc_q        <= acc_d;
			taken_q      <= taken_d;
			cur_q        <= cur_d;
			emitted_q    <= emitted_d;
			fill_done_q  <= fill_done_d;
			bitcnt_q     <= bitcnt_d;
			pend_valid_q <= pend_valid_d;
			if (rel) begin
				out_valid_q <= 1'b1;
			end else if (pixels.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		byte_q      <= byte_d;
		pend_idx_q  <= pend_idx_d;
		pend_done_q <= pend_done_d;
		if (rel) begin
			out_idx_q  <= rel_idx;
			out_last_q <= rel_last;
			out_done_q <= rel_done;
			out_oor_q  <= ({1'b0, rel_idx} >= IDX_LIMIT);
		end
	end

	// Palette memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			pal_mem[head.item.palette_index[AW-1:0]] <= head.item.palette_rgb;
		end
		if (rel) begin
			rgb_q <= pal_mem[rel_idx[AW-1:0]];
		end
	end

	// Next state: take requests, decode one bit a cycle unless a stalled output holds the decoder, hand pixels on.
	always_comb begin
		state_d      = state_q;
		phase_d      = phase_q;
		acc_d        = acc_q;
		taken_d      = taken_q;
		cur_d        = cur_q;
		emitted_d    = emitted_q;
		fill_done_d  = fill_done_q;
		byte_d       = byte_q;
		bitcnt_d     = bitcnt_q;
		pend_valid_d = pend_valid_q;
		pend_idx_d   = pend_idx_q;
		pend_done_d  = pend_done_q;
		pop          = 1'b0;
		mem_we       = 1'b0;
		rel          = 1'b0;
		rel_idx      = pend_idx_q;
		rel_last     = 1'b0;
		rel_done     = pend_done_q;
		pix          = 1'b0;
		pix_color    = cur_q;
		acc_n        = acc_q;
		taken_n      = taken_q;

		case (state_q)
			dpbd_pkg::BK_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					if (!head.is_data) begin
						mem_we = ({1'b0, head.item.palette_index} < IDX_LIMIT);
					end else begin
						byte_d   = head.item.data_byte;
						bitcnt_d = '0;
						state_d  = fill_done_q ? dpbd_pkg::BK_BITS : dpbd_pkg::BK_FILL;
					end
				end
			end
			dpbd_pkg::BK_FILL: begin
				// The first pixel of an image is the fill color.
				if (step_ok) begin
					cur_d       = cfg.fill_index;
					fill_done_d = 1'b1;
					pix         = 1'b1;
					pix_color   = cfg.fill_index;
					state_d     = dpbd_pkg::BK_BITS;
				end
			end
			dpbd_pkg::BK_BITS: begin
				if (step_ok) begin
					bitcnt_d = bitcnt_q + 1'b1;
					if (bitcnt_q == dpbd_pkg::LAST_BIT) begin
						state_d = dpbd_pkg::BK_END;
					end
					case (phase_q)
						dpbd_pkg::PH_FIRST: begin
							if (!cur_bit) begin
								pix = 1'b1;
							end else begin
								phase_d = dpbd_pkg::PH_SECOND;
							end
						end
						dpbd_pkg::PH_SECOND: begin
							acc_d   = '0;
							taken_d = '0;
							if (cur_bit) begin
								phase_d = dpbd_pkg::PH_DELTA;
							end else if (width == '0) begin
								cur_d = '0;
								pix   = 1'b1;
							end else begin
								phase_d = dpbd_pkg::PH_LOAD;
							end
						end
						dpbd_pkg::PH_DELTA: begin
							if (taken_q < dpbd_pkg::DELTA_LEN) begin
								acc_n = acc_q | ({7'd0, cur_bit} << taken_q[2:0]);
							end
							taken_n = taken_q + 1'b1;
							acc_d   = acc_n;
							taken_d = taken_n;
							if (taken_n >= dpbd_pkg::DELTA_LEN) begin
								cur_d = cur_q + dpbd_pkg::delta_step(acc_n[2:0]);
								pix   = 1'b1;
							end
						end
						dpbd_pkg::PH_LOAD: begin
							if (taken_q < dpbd_pkg::LOAD_MAX) begin
								acc_n = acc_q | ({7'd0, cur_bit} << taken_q[2:0]);
							end
							taken_n = taken_q + 1'b1;
							acc_d   = acc_n;
							taken_d = taken_n;
							if (taken_n >= width) begin
								cur_d = acc_n;
								pix   = 1'b1;
							end
						end
						default: begin
							phase_d = dpbd_pkg::PH_FIRST;
						end
					endcase
					pix_color = cur_d;
				end
			end
			dpbd_pkg::BK_END: begin
				// The pixel still held is the last one of this byte.
				if (!pend_valid_q) begin
					state_d = dpbd_pkg::BK_IDLE;
				end else if (out_free) begin
					rel          = 1'b1;
					rel_last     = 1'b1;
					pend_valid_d = 1'b0;
					state_d      = dpbd_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = dpbd_pkg::BK_IDLE;
			end
		endcase

		// A new pixel pushes the held one out and counts toward the image.
		if (pix) begin
			if (pend_valid_q) begin
				rel = 1'b1;
			end
			pend_valid_d = 1'b1;
			pend_idx_d   = pix_color;
			pend_done_d  = img_done;
			emitted_d    = emitted_n;
			phase_d      = dpbd_pkg::PH_FIRST;
			acc_d        = '0;
			taken_d      = '0;
			if (img_done) begin
				// Image complete: drop the rest of the byte, await a new image.
				emitted_d   = '0;
				fill_done_d = 1'b0;
				state_d     = dpbd_pkg::BK_END;
			end
		end
	end

	assign pixels.valid       = out_valid_q;
	assign pixels.pixel_index = out_idx_q;
	assign pixels.last_of_run = out_last_q;
	assign pixels.image_done  = out_done_q;
	assign pixels.pixel_rgb   = out_oor_q ? '0 : rgb_q;

endmodule

### src/delta_palette_bitstream_image_decoder_core.sv
// Top level of the delta-palette bitstream image decoder.
// Depends on dpbd_pkg, dpbd_in_if, dpbd_out_if, dpbd_front and dpbd_back.
//
//   Channel   Direction   Moves                              Handshake
//   cmd       in          palette write or compressed byte   valid/ready
//   pixels    out         decoded pixel, index and flags     valid/ready
//   cfg       in          register write                     cfg_we only
//
// In the back part a palette write is done as it leaves the queue. A data byte leaves
// the queue, passes bit by bit through the serial decoder and then hands on its
// final pixel; the first byte of an image also emits the fill pixel, and a byte
// that completes the image ends early. Reset clears all control state;
// the palette memory is not cleared and is undefined until written. A stalled
// pixel output holds the decoder once its one-pixel holding stage is full, while
// the two-entry request queue keeps accepting until it is full.
`timescale 1ns / 1ps

module delta_palette_bitstream_image_decoder_core #(
	parameter int unsigned PALETTE_DEPTH = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dpbd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dpbd_pkg::CFG_DATA_W-1:0]   cfg_data,
	dpbd_in_if.sink                           cmd,
	dpbd_out_if.source                        pixels
);

	dpbd_pkg::cfg_t  cfg_q;
	dpbd_pkg::head_t head;
	logic            pop;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.palette_bits <= dpbd_pkg::PBITS_RESET;
			cfg_q.fill_index   <= dpbd_pkg::FILL_RESET;
			cfg_q.pixel_count  <= dpbd_pkg::PCOUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				dpbd_pkg::CFG_PALETTE_BITS:
					cfg_q.palette_bits <= cfg_data[dpbd_pkg::PBITS_W-1:0];
				dpbd_pkg::CFG_FILL_INDEX:
					cfg_q.fill_index <= cfg_data[dpbd_pkg::IDX_W-1:0];
				dpbd_pkg::CFG_PIXEL_COUNT:
					cfg_q.pixel_count <= cfg_data[dpbd_pkg::PCOUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	dpbd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.pop    (pop),
		.head   (head)
	);

	dpbd_back #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.cfg    (cfg_q),
		.pop    (pop),
		.pixels (pixels)
	);

endmodule

### src/dpbd_checker.sv
// Port-level checks of the decoder, attached to the top level by bind.
// Depends on dpbd_pkg and delta_palette_bitstream_image_decoder_core.
`timescale 1ns / 1ps

module dpbd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cfg_we,
	input logic [dpbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [dpbd_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic                            pix_valid,
	input logic                            pix_ready,
	input logic [dpbd_pkg::RGB_W-1:0]      pixel_rgb,
	input logic [dpbd_pkg::IDX_W-1:0]      pixel_index,
	input logic                            last_of_run,
	input logic                            image_done
);

	// Tracks whether every image is a single pixel.
	logic single_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_q <= 1'b1;
		end else if (cfg_we && (cfg_index == dpbd_pkg::CFG_PIXEL_COUNT)) begin
			single_q <= (cfg_data[dpbd_pkg::PCOUNT_W-1:0] <= dpbd_pkg::PCOUNT_W'(1));
		end
	end

	// A stalled pixel keeps its whole payload.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(pixel_rgb)
			&& $stable(pixel_index) && $stable(last_of_run) && $stable(image_done))
		else $error("pixel payload changed while stalled");

	// The pixel that ends an image is always the last one of its byte.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && image_done |-> last_of_run)
		else $error("image ended on a pixel that is not last of its byte");

	// With one pixel per image every pixel completes its image.
	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && single_q |-> image_done && last_of_run)
		else $error("single-pixel image did not complete");

endmodule

bind delta_palette_bitstream_image_decoder_core dpbd_checker u_dpbd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_we      (cfg_we),
	.cfg_index   (cfg_index),
	.cfg_data    (cfg_data),
	.pix_valid   (pixels.valid),
	.pix_ready   (pixels.ready),
	.pixel_rgb   (pixels.pixel_rgb),
	.pixel_index (pixels.pixel_index),
	.last_of_run (pixels.last_of_run),
	.image_done  (pixels.image_done)
);

### bench/tb_top.sv
// Self-checking bench for the delta-palette bitstream image decoder core.
// A clocked driver and monitor run around a predictor that decodes every queued
// request; depends on dpbd_pkg, dpbd_in_if, dpbd_out_if and the core itself.
`timescale 1ns / 1ps

module tb_top;
	import dpbd_pkg::*;

	localparam int unsigned PAL_ENTRIES  = 256;
	localparam int unsigned DRAIN_CYCLES = 60;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned RAND_PER_PHASE = 14;

	// Idle mix of sender and receiver, in percent.
	typedef enum int {
		MODE_NONE,
		MODE_SEND_IDLE,
		MODE_RECV_STALL,
		MODE_BOTH
	} idle_mode_t;

	typedef struct packed {
		logic [RGB_W-1:0] rgb;
		logic [IDX_W-1:0] idx;
		logic             last;
		logic             done;
	} pixel_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dpbd_in_if  cmd();
	dpbd_out_if pixels();

	delta_palette_bitstream_image_decoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.pixels    (pixels)
	);

	// Decoder mirror: palette, color, code position and register copies.
	logic [RGB_W-1:0]    pal_mirror [PAL_ENTRIES];
	bit                  pal_written [PAL_ENTRIES];
	logic [IDX_W-1:0]    color_now;
	logic [PCOUNT_W-1:0] emitted_now;
	phase_t              code_now;
	logic [IDX_W-1:0]    field_acc;
	logic [TAKEN_W-1:0]  field_taken;
	logic                fill_sent;
	logic [PBITS_W-1:0]  pbits_cfg;
	logic [IDX_W-1:0]    fill_cfg;
	logic [PCOUNT_W-1:0] count_cfg;

	pixel_t run_pixels[$];
	pixel_t pixels_due[$];
	item_t  pending_items[$];
	item_t  offered_item;

	bit offering;
	bit cmd_took;
	int fail_count;
	int cycle_count;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_arm;
	int hold_seen;
	int hold_left;

	// Free-running clock, 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		fail_count++;
	endtask

	// Color step of a delta code: codes 0..3 step down by 4..1, codes 4..7 up by 1..4.
	function automatic logic [IDX_W-1:0] step_of(input logic [2:0] sel);
		return sel[2] ? ({5'd0, sel} - 8'd3) : ({5'd0, sel} - 8'd4);
	endfunction

	// Emits the current color as one pixel; returns 1 when the image is complete.
	function automatic logic emit_pixel();
		logic [PCOUNT_W-1:0] limit;
		pixel_t px;
		limit = (count_cfg == '0) ? PCOUNT_W'(1) : count_cfg;
		emitted_now = emitted_now + 1'b1;
		px.rgb = pal_mirror[color_now];
		px.idx = color_now;
		px.last = 1'b0;
		px.done = (emitted_now >= limit);
		run_pixels.insert(run_pixels.size(), px);
		return px.done;
	endfunction

	// Works out the pixels that one request causes, in the order of the requests.
	task automatic predict_request(input item_t it);
		logic done;
		logic b;
		logic pix;
		logic [PBITS_W-1:0] width;
		pixel_t px;
		if (it.opcode == OP_PALETTE) begin
			pal_mirror[it.palette_index] = it.palette_rgb;
			return;
		end
		run_pixels.delete();
		done = 1'b0;
		// The first byte of an image starts with the fill pixel.
		if (!fill_sent) begin
			fill_sent = 1'b1;
			color_now = fill_cfg;
			done = emit_pixel();
		end
		for (int i = 0; i < 8 && !done; i++) begin
			b = it.data_byte[i];
			width = (pbits_cfg > PBITS_MAX) ? PBITS_MAX : pbits_cfg;
			pix = 1'b0;
			case (code_now)
				PH_FIRST: begin
					if (!b) begin
						pix = 1'b1;
					end else begin
						code_now = PH_SECOND;
					end
				end
				PH_SECOND: begin
					field_acc = '0;
					field_taken = '0;
					if (b) begin
						code_now = PH_DELTA;
					end else if (width == '0) begin
						color_now = '0;
						pix = 1'b1;
					end else begin
						code_now = PH_LOAD;
					end
				end
				PH_DELTA: begin
					if (field_taken < DELTA_LEN) field_acc[field_taken[2:0]] = b;
					field_taken = field_taken + 1'b1;
					if (field_taken >= DELTA_LEN) begin
						color_now = color_now + step_of(field_acc[2:0]);
						pix = 1'b1;
					end
				end
				default: begin
					if (field_taken < LOAD_MAX) field_acc[field_taken[2:0]] = b;
					field_taken = field_taken + 1'b1;
					if (field_taken >= TAKEN_W'(width)) begin
						color_now = field_acc;
						pix = 1'b1;
					end
				end
			endcase
			if (pix) begin
				code_now = PH_FIRST;
				field_acc = '0;
				field_taken = '0;
				done = emit_pixel();
			end
		end
		// The final pixel of this request carries the run flag.
		if (run_pixels.size() > 0) begin
			px = run_pixels.pop_back();
			px.last = 1'b1;
			run_pixels.insert(run_pixels.size(), px);
		end
		foreach (run_pixels[k]) pixels_due.insert(pixels_due.size(), run_pixels[k]);
		// A finished image drops the rest of the byte and waits for a new fill pixel.
		if (done) begin
			emitted_now = '0;
			code_now = PH_FIRST;
			field_acc = '0;
			field_taken = '0;
			fill_sent = 1'b0;
		end
	endtask

	// Request driver: offers the next pending item and holds it until it is taken.
	always @(negedge clk) begin
		if (offering && cmd_took) offering = 1'b0;
		if (!offering && pending_items.size() > 0 &&
				$urandom_range(99) >= send_idle_pct) begin
			offered_item = pending_items.pop_front();
			offering = 1'b1;
			cmd.opcode <= offered_item.opcode;
			cmd.palette_index <= offered_item.palette_index;
			cmd.palette_rgb <= offered_item.palette_rgb;
			cmd.data_byte <= offered_item.data_byte;
		end
		cmd.valid <= offering;
	end

	// Pixel receiver: random stalls, plus one long hold-off when armed.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			pixels.ready <= 1'b0;
		end else if (hold_seen != hold_arm) begin
			hold_seen = hold_arm;
			hold_left = HOLD_CYCLES;
			pixels.ready <= 1'b0;
		end else begin
			pixels.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: notes each accepted request and checks each accepted pixel.
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n) begin
			cmd_took = cmd.valid && cmd.ready;
			if (pixels.valid && pixels.ready) begin
				if (pixels_due.size() == 0) begin
					report_mismatch($sformatf("unexpected pixel index %0h rgb %0h",
						pixels.pixel_index, pixels.pixel_rgb));
				end else begin
					want = pixels_due.pop_front();
					if (pixels.pixel_rgb !== want.rgb)
						report_mismatch($sformatf("pixel_rgb %0h, expected %0h",
							pixels.pixel_rgb, want.rgb));
					if (pixels.pixel_index !== want.idx)
						report_mismatch($sformatf("pixel_index %0h, expected %0h",
							pixels.pixel_index, want.idx));
					if (pixels.last_of_run !== want.last)
						report_mismatch($sformatf("last_of_run %0b, expected %0b",
							pixels.last_of_run, want.last));
					if (pixels.image_done !== want.done)
						report_mismatch($sformatf("image_done %0b, expected %0b",
							pixels.image_done, want.done));
				end
			end
		end else begin
			cmd_took = 1'b0;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic set_mode(input idle_mode_t mode);
		case (mode)
			MODE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			MODE_SEND_IDLE: begin
				send_idle_pct = 68;
				recv_stall_pct = 0;
			end
			MODE_RECV_STALL: begin
				send_idle_pct = 0;
				recv_stall_pct = 68;
			end
			default: begin
				send_idle_pct = 17;
				recv_stall_pct = 17;
			end
		endcase
	endtask

	// Register write on the falling edge; the mirror follows at once since the core is idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_PALETTE_BITS: pbits_cfg = val[PBITS_W-1:0];
			CFG_FILL_INDEX:   fill_cfg = val[IDX_W-1:0];
			CFG_PIXEL_COUNT:  count_cfg = val[PCOUNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every request is taken and every pixel has come, then lets the core settle.
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_items.size() != 0 || offering || pixels_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic start_phase(input idle_mode_t mode, input logic [PBITS_W-1:0] pbits,
			input logic [IDX_W-1:0] fill, input logic [PCOUNT_W-1:0] count);
		wait_idle();
		write_reg(CFG_PALETTE_BITS, CFG_DATA_W'(pbits));
		write_reg(CFG_FILL_INDEX, CFG_DATA_W'(fill));
		write_reg(CFG_PIXEL_COUNT, CFG_DATA_W'(count));
		set_mode(mode);
	endtask

	// Predicts a request and hands it to the driver.
	task automatic queue_item(input item_t it);
		predict_request(it);
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic queue_palette(input logic [IDX_W-1:0] idx, input logic [RGB_W-1:0] rgb);
		item_t it;
		it.opcode = OP_PALETTE;
		it.palette_index = idx;
		it.palette_rgb = rgb;
		it.data_byte = BYTE_W'($urandom);
		pal_written[idx] = 1'b1;
		queue_item(it);
	endtask

	// A data byte is preceded by writes of any palette entry that it reads for the first time.
	task automatic queue_data(input logic [BYTE_W-1:0] b);
		item_t               it;
		logic [IDX_W-1:0]    s_color;
		logic [PCOUNT_W-1:0] s_emitted;
		phase_t              s_code;
		logic [IDX_W-1:0]    s_acc;
		logic [TAKEN_W-1:0]  s_taken;
		logic                s_fill;
		int                  base;
		logic [IDX_W-1:0]    need[$];
		pixel_t              px;
		it.opcode = OP_DATA;
		it.palette_index = IDX_W'($urandom);
		it.palette_rgb = RGB_W'($urandom);
		it.data_byte = b;
		// Trial decode to learn which entries the byte reads, then undo it.
		s_color = color_now;
		s_emitted = emitted_now;
		s_code = code_now;
		s_acc = field_acc;
		s_taken = field_taken;
		s_fill = fill_sent;
		base = pixels_due.size();
		predict_request(it);
		while (pixels_due.size() > base) begin
			px = pixels_due.pop_back();
			if (!pal_written[px.idx]) need.insert(need.size(), px.idx);
		end
		color_now = s_color;
		emitted_now = s_emitted;
		code_now = s_code;
		field_acc = s_acc;
		field_taken = s_taken;
		fill_sent = s_fill;
		foreach (need[k]) begin
			if (!pal_written[need[k]]) queue_palette(need[k], RGB_W'($urandom));
		end
		queue_item(it);
	endtask

	initial begin
		logic [PBITS_W-1:0] pb;
		logic [PCOUNT_W-1:0] cnt;
		// Every input known from time zero; mirror starts at the reset state.
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cmd.valid = 1'b0;
		cmd.opcode = OP_PALETTE;
		cmd.palette_index = '0;
		cmd.palette_rgb = '0;
		cmd.data_byte = '0;
		pixels.ready = 1'b0;
		fail_count = 0;
		cycle_count = 0;
		hold_arm = 0;
		hold_seen = 0;
		hold_left = 0;
		set_mode(MODE_NONE);
		pbits_cfg = PBITS_RESET;
		fill_cfg = FILL_RESET;
		count_cfg = PCOUNT_RESET;
		color_now = '0;
		emitted_now = '0;
		code_now = PH_FIRST;
		field_acc = '0;
		field_taken = '0;
		fill_sent = 1'b0;
		foreach (pal_written[i]) pal_written[i] = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Reset settings: one pixel per image, so each byte gives only its fill pixel.
		queue_data(8'h00);
		queue_data(8'hFF);

		// Long image: nine pixels from one byte, every delta code, then loads.
		start_phase(MODE_SEND_IDLE, 4'd8, 8'hFF, 21'h100000);
		queue_data(8'h00);
		for (int s = 0; s < 8; s++) queue_data({3'b000, 3'(s), 2'b11});
		queue_data(8'h01);
		queue_data(8'h86);
		queue_palette(IDX_W'($urandom), RGB_W'($urandom));
		queue_data(8'h8A);
		queue_data(8'hFF);

		// Zero code width loads color 0; the lowered count ends the open image at once.
		start_phase(MODE_RECV_STALL, 4'd0, 8'd5, 21'd3);
		queue_data(8'h5A);
		queue_data(8'h02);
		queue_data(8'hF6);

		// Width above eight; the phase stops six bits into a color load.
		start_phase(MODE_BOTH, 4'd15, 8'h80, 21'h1FFFFF);
		queue_data(8'h00);
		queue_data(8'hFD);

		// Narrower width ends that load on its next bit; a zero count acts as one.
		start_phase(MODE_NONE, 4'd4, 8'h7F, 21'd0);
		queue_data(8'h55);
		queue_data(8'h33);

		// Random phases through all idle mixes and several register settings.
		for (int r = 0; r < 4; r++) begin
			case (r)
				0: begin
					pb = 4'd4;
					cnt = PCOUNT_W'($urandom_range(1, 12));
				end
				1: begin
					pb = 4'd9;
					cnt = PCOUNT_W'($urandom_range(1, 40));
				end
				2: begin
					pb = 4'd8;
					cnt = PCOUNT_W'($urandom_range(200, 600));
				end
				default: begin
					pb = PBITS_W'($urandom_range(4, 8));
					cnt = PCOUNT_W'($urandom_range(1, 20));
				end
			endcase
			start_phase(idle_mode_t'(r), pb, IDX_W'($urandom), cnt);
			for (int k = 0; k < RAND_PER_PHASE; k++) begin
				if ($urandom_range(9) == 0) queue_palette(IDX_W'($urandom), RGB_W'($urandom));
				else queue_data(BYTE_W'($urandom));
			end
			// Long receiver hold-off while the sender keeps offering requests.
			if (r == 0) hold_arm++;
		end

		wait_idle();
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### sim.f
src/dpbd_pkg.sv
src/dpbd_in_if.sv
src/dpbd_out_if.sv
src/dpbd_front.sv
src/dpbd_back.sv
src/delta_palette_bitstream_image_decoder_core.sv
src/dpbd_checker.sv
bench/tb_top.sv
